// File: src/tsb_pkg.sv
// tsb_pkg: shared constants, register indexes, item kinds and structs of the
// texture sampler. No dependencies; every other file of the block imports it.
package tsb_pkg;

	localparam int STORE_TEXELS  = 65536;
	localparam int MAX_DIMENSION = 4096;
	localparam int WEIGHT_BITS   = 8;

	localparam int ADDR_W     = $clog2(STORE_TEXELS);
	localparam int DIM_W      = 13;
	localparam int PITCH_W    = 17;
	localparam int INDEX_W    = 16;
	localparam int TEXEL_W    = 32;
	localparam int COORD_W    = 32;
	localparam int CHAN_W     = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam int FRAC_W      = 16;
	localparam int UNIT        = 1 << FRAC_W;
	localparam int HALF        = 1 << (FRAC_W - 1);
	localparam int MAP_W       = FRAC_W + 1;
	localparam int SCALED_W    = MAP_W + DIM_W;
	localparam int WIDE_ADDR_W = DIM_W + PITCH_W;

	localparam int WT_W       = WEIGHT_BITS + 1;
	localparam int PROD_WT_W  = 2 * WEIGHT_BITS + 1;
	localparam int ACC_W      = 8 + 2 * WEIGHT_BITS;
	localparam int SHIFT_DOWN = (2 * WEIGHT_BITS >= 16) ? 2 * WEIGHT_BITS - 16 : 0;
	localparam int SHIFT_UP   = (2 * WEIGHT_BITS < 16) ? 16 - 2 * WEIGHT_BITS : 0;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MODE   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_BILINEAR_MODE = CFG_IDX_W'(4);

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} command_t;

	typedef enum logic [2:0] {
		KIND_WRITE,
		KIND_DROP,
		KIND_ERROR,
		KIND_NEAREST,
		KIND_BILINEAR
	} kind_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_WRITE,
		B_ERROR,
		B_READ,
		B_DRAIN
	} back_state_t;

	typedef struct packed {
		logic [DIM_W-1:0]   tex_width;
		logic [DIM_W-1:0]   tex_height;
		logic [PITCH_W-1:0] row_pitch;
		logic               repeat_mode;
		logic               bilinear_mode;
	} cfg_t;

	typedef struct packed {
		kind_t                    kind;
		logic [3:0][ADDR_W-1:0]   addr;
		logic [WEIGHT_BITS-1:0]   wx;
		logic [WEIGHT_BITS-1:0]   wy;
		logic [TEXEL_W-1:0]       texel;
	} entry_t;

endpackage

// File: src/tsb_front.sv
// tsb_front: classifies accepted items, maps coordinates and computes the
// texel addresses and weights of a sample. Depends on tsb_pkg.
module tsb_front import tsb_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       accept,
	input  logic                       command,
	input  logic [INDEX_W-1:0]         texel_index,
	input  logic [TEXEL_W-1:0]         texel_rgba,
	input  logic signed [COORD_W-1:0]  coord_u,
	input  logic signed [COORD_W-1:0]  coord_v,
	output logic                       push,
	output entry_t                     push_entry
);

	function automatic logic [MAP_W-1:0] map_coord(input logic [COORD_W-1:0] raw,
			input logic rep);
		logic [MAP_W-1:0] r;
		if (rep) begin
			r = MAP_W'(raw[FRAC_W-1:0]);
		end else if (raw[COORD_W-1]) begin
			r = '0;
		end else if (raw > COORD_W'(UNIT)) begin
			r = MAP_W'(UNIT);
		end else begin
			r = raw[MAP_W-1:0];
		end
		return r;
	endfunction

	// index one below h, wrapped or clamped
	function automatic logic [DIM_W-1:0] fix_low(input logic [DIM_W-1:0] h,
			input logic [DIM_W-1:0] size, input logic rep);
		logic [DIM_W-1:0] r;
		if (h == '0) begin
			r = rep ? size - DIM_W'(1) : '0;
		end else begin
			r = h - DIM_W'(1);
		end
		return r;
	endfunction

	// index h, which may equal size
	function automatic logic [DIM_W-1:0] fix_high(input logic [DIM_W-1:0] h,
			input logic [DIM_W-1:0] size, input logic rep);
		logic [DIM_W-1:0] r;
		if (h == size) begin
			r = rep ? '0 : size - DIM_W'(1);
		end else begin
			r = h;
		end
		return r;
	endfunction

	logic [WIDE_ADDR_W-1:0] span_c;
	logic                   err_c;
	logic                   write_ok_c;
	logic [MAP_W-1:0]       map_u_c, map_v_c;

	logic                   valid_s1;
	kind_t                  kind_s1;
	logic [SCALED_W-1:0]    su_s1, sv_s1;
	logic [INDEX_W-1:0]     index_s1;
	logic [TEXEL_W-1:0]     texel_s1;

	logic [SCALED_W-1:0]    px_c, py_c;
	logic [DIM_W-1:0]       hx_c, hy_c, nx_c, ny_c;
	logic [DIM_W-1:0]       xa_c, xb_c, ya_c, yb_c;
	logic [WIDE_ADDR_W-1:0] row_a_c, row_b_c;
	logic                   bil_c;

	assign span_c = WIDE_ADDR_W'(cfg.tex_height - DIM_W'(1)) * WIDE_ADDR_W'(cfg.row_pitch);

	assign err_c = (cfg.tex_width == '0) || (cfg.tex_height == '0) ||
		(32'(cfg.tex_width) > 32'(MAX_DIMENSION)) ||
		(32'(cfg.tex_height) > 32'(MAX_DIMENSION)) ||
		(cfg.row_pitch < PITCH_W'(cfg.tex_width)) ||
		(32'(span_c) + 32'(cfg.tex_width) > 32'(STORE_TEXELS));

	assign write_ok_c = 32'(texel_index) < 32'(STORE_TEXELS);
	assign map_u_c    = map_coord(coord_u, cfg.repeat_mode);
	assign map_v_c    = map_coord(coord_v, cfg.repeat_mode);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (command_t'(command) == CMD_WRITE) begin
				kind_s1 <= write_ok_c ? KIND_WRITE : KIND_DROP;
			end else if (err_c) begin
				kind_s1 <= KIND_ERROR;
			end else begin
				kind_s1 <= cfg.bilinear_mode ? KIND_BILINEAR : KIND_NEAREST;
			end
			su_s1    <= SCALED_W'(map_u_c) * SCALED_W'(cfg.tex_width);
			sv_s1    <= SCALED_W'(map_v_c) * SCALED_W'(cfg.tex_height);
			index_s1 <= texel_index;
			texel_s1 <= texel_rgba;
		end
	end

	// bilinear indices come from floor(X + 1), nearest from floor(u * size)
	assign px_c  = su_s1 + SCALED_W'(HALF);
	assign py_c  = sv_s1 + SCALED_W'(HALF);
	assign hx_c  = px_c[FRAC_W +: DIM_W];
	assign hy_c  = py_c[FRAC_W +: DIM_W];
	assign nx_c  = su_s1[FRAC_W +: DIM_W];
	assign ny_c  = sv_s1[FRAC_W +: DIM_W];
	assign bil_c = kind_s1 == KIND_BILINEAR;

	assign xa_c = bil_c ? fix_low(hx_c, cfg.tex_width, cfg.repeat_mode)
		: fix_high(nx_c, cfg.tex_width, cfg.repeat_mode);
	assign ya_c = bil_c ? fix_low(hy_c, cfg.tex_height, cfg.repeat_mode)
		: fix_high(ny_c, cfg.tex_height, cfg.repeat_mode);
	assign xb_c = fix_high(hx_c, cfg.tex_width, cfg.repeat_mode);
	assign yb_c = fix_high(hy_c, cfg.tex_height, cfg.repeat_mode);

	assign row_a_c = WIDE_ADDR_W'(ya_c) * WIDE_ADDR_W'(cfg.row_pitch);
	assign row_b_c = WIDE_ADDR_W'(yb_c) * WIDE_ADDR_W'(cfg.row_pitch);

	assign push = valid_s1;

	always_comb begin
		push_entry       = '0;
		push_entry.kind  = kind_s1;
		push_entry.texel = texel_s1;
		if (kind_s1 == KIND_WRITE || kind_s1 == KIND_DROP) begin
			push_entry.addr[0] = ADDR_W'(index_s1);
		end else begin
			push_entry.addr[0] = ADDR_W'(row_a_c + WIDE_ADDR_W'(xa_c));
			push_entry.addr[1] = ADDR_W'(row_a_c + WIDE_ADDR_W'(xb_c));
			push_entry.addr[2] = ADDR_W'(row_b_c + WIDE_ADDR_W'(xa_c));
			push_entry.addr[3] = ADDR_W'(row_b_c + WIDE_ADDR_W'(xb_c));
			if (bil_c) begin
				push_entry.wx = px_c[FRAC_W-1 -: WEIGHT_BITS];
				push_entry.wy = py_c[FRAC_W-1 -: WEIGHT_BITS];
			end
		end
	end

endmodule

// File: src/tsb_queue.sv
// tsb_queue: short first-in first-out queue of classified items between the
// front and the back of the sampler. Depends on tsb_pkg.
module tsb_queue import tsb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   empty
);

	entry_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign head  = slot_q[rd_ptr_q];
	assign empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && count_q == QCNT_W'(QUEUE_DEPTH)))
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && count_q == '0))
		else $error("queue underflow");
`endif

endmodule

// File: src/tsb_back.sv
// tsb_back: texel store and sequencer; performs writes, reads one or four
// texels per sample and blends them. Depends on tsb_pkg.
module tsb_back import tsb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  entry_t                 head,
	input  logic                   empty,
	output logic                   pop,
	output logic                   done,
	output logic                   status,
	output logic [3:0][CHAN_W-1:0] chan
);

	back_state_t            state_q, state_d;
	entry_t                 cur_q;
	logic [1:0]             rd_cnt_q;
	logic                   load, issue, mem_we, last_read;
	logic [ADDR_W-1:0]      mem_addr;

	logic [TEXEL_W-1:0]     mem [STORE_TEXELS];
	logic [TEXEL_W-1:0]     rdata_q;
	logic                   rvalid_s1;

	logic [WT_W-1:0]        wa_c, wb_c;
	logic [PROD_WT_W-1:0]   weight_c, weight_s1;
	logic [3:0][ACC_W-1:0]  acc_q, sum_c;

	logic                   done_q, status_q;
	logic [3:0][CHAN_W-1:0] chan_q;

	assign last_read = (cur_q.kind == KIND_BILINEAR) ? (rd_cnt_q == 2'd3) : 1'b1;

	always_comb begin
		state_d = state_q;
		if (state_q == B_READ) begin
			if (last_read) begin
				state_d = B_DRAIN;
			end
		end else if (!empty) begin
			unique case (head.kind)
				KIND_WRITE:                 state_d = B_WRITE;
				KIND_ERROR:                 state_d = B_ERROR;
				KIND_NEAREST, KIND_BILINEAR: state_d = B_READ;
				default:                    state_d = B_IDLE;
			endcase
		end else begin
			state_d = B_IDLE;
		end
	end

	always_comb begin
		load     = (state_q != B_READ) && !empty;
		issue    = state_q == B_READ;
		mem_we   = state_q == B_WRITE;
		mem_addr = cur_q.addr[rd_cnt_q];
	end

	assign pop = load;

	// weight of corner: bit 0 picks right column, bit 1 picks lower row
	assign wa_c = rd_cnt_q[0] ? WT_W'(cur_q.wx) : WT_W'(1 << WEIGHT_BITS) - WT_W'(cur_q.wx);
	assign wb_c = rd_cnt_q[1] ? WT_W'(cur_q.wy) : WT_W'(1 << WEIGHT_BITS) - WT_W'(cur_q.wy);
	assign weight_c = PROD_WT_W'(wa_c) * PROD_WT_W'(wb_c);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= cur_q.texel;
		end else if (issue) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			rd_cnt_q  <= '0;
			rvalid_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= issue;
			done_q    <= (state_q == B_DRAIN) || (state_q == B_ERROR);
			if (load) begin
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + 2'd1;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sum_c[k] = acc_q[k] + ACC_W'(rdata_q[8*k +: 8]) * ACC_W'(weight_s1);
		end
	end

	always_ff @(posedge clk) begin
		weight_s1 <= weight_c;
		if (load) begin
			cur_q <= head;
			acc_q <= '0;
		end else if (rvalid_s1) begin
			acc_q <= sum_c;
		end
		if (state_q == B_ERROR) begin
			status_q <= 1'b1;
			chan_q   <= '0;
		end else if (state_q == B_DRAIN) begin
			status_q <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				chan_q[k] <= CHAN_W'((64'(sum_c[k]) >> SHIFT_DOWN) << SHIFT_UP);
			end
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign chan   = chan_q;

`ifndef NO_ASSERTIONS
	a_drain_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DRAIN |-> rvalid_s1)
		else $error("drain without read data");
	a_nearest_one_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ && cur_q.kind != KIND_BILINEAR) |=> state_q == B_DRAIN)
		else $error("nearest sample issued more than one read");
	a_no_write_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !rvalid_s1)
		else $error("store write while read data in flight");
`endif

endmodule

// File: src/texture_sampler_bilinear_unit.sv
// texture_sampler_bilinear_unit: top level of the texture sampler; holds the
// configuration registers and credit count. Depends on tsb_pkg, tsb_front,
// tsb_queue and tsb_back.
//
//   channel   ports                                         handshake
//   item in   command texel_index texel_rgba coord_u/v      start && !busy
//   result    status chan_red chan_green chan_blue chan_alpha  done, one cycle
//   config    cfg_index cfg_data                            cfg_we
//
// an accepted item passes through the front stage register and the queue to
// the back end; a bilinear sample makes four reads of the single-port store,
// one per corner, a nearest sample one, and both sum in the drain state; done
// and the result are registered from the drain or error state
// busy rises when four items sit in the front stage and queue
// arst_n clears control state; the store is undefined until written
// results cannot be held off by the receiver
module texture_sampler_bilinear_unit import tsb_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      command,
	input  logic [INDEX_W-1:0]        texel_index,
	input  logic [TEXEL_W-1:0]        texel_rgba,
	input  logic signed [COORD_W-1:0] coord_u,
	input  logic signed [COORD_W-1:0] coord_v,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	output logic                      done,
	output logic                      status,
	output logic [CHAN_W-1:0]         chan_red,
	output logic [CHAN_W-1:0]         chan_green,
	output logic [CHAN_W-1:0]         chan_blue,
	output logic [CHAN_W-1:0]         chan_alpha
);

	cfg_t                   cfg_q;
	logic [QCNT_W-1:0]      credits_q;
	logic                   accept, push, pop, empty;
	entry_t                 push_entry, head;
	logic [3:0][CHAN_W-1:0] chan;

	assign busy   = credits_q == QCNT_W'(QUEUE_DEPTH);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tex_width     <= DIM_W'(1);
			cfg_q.tex_height    <= DIM_W'(1);
			cfg_q.row_pitch     <= PITCH_W'(1);
			cfg_q.repeat_mode   <= 1'b0;
			cfg_q.bilinear_mode <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEX_WIDTH:     cfg_q.tex_width     <= cfg_data[DIM_W-1:0];
				REG_TEX_HEIGHT:    cfg_q.tex_height    <= cfg_data[DIM_W-1:0];
				REG_ROW_PITCH:     cfg_q.row_pitch     <= cfg_data[PITCH_W-1:0];
				REG_REPEAT_MODE:   cfg_q.repeat_mode   <= cfg_data[0];
				REG_BILINEAR_MODE: cfg_q.bilinear_mode <= cfg_data[0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// one credit per item between acceptance and leaving the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credits_q <= '0;
		end else begin
			unique case ({accept, pop})
				2'b10:   credits_q <= credits_q + QCNT_W'(1);
				2'b01:   credits_q <= credits_q - QCNT_W'(1);
				default: credits_q <= credits_q;
			endcase
		end
	end

	tsb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.accept      (accept),
		.command     (command),
		.texel_index (texel_index),
		.texel_rgba  (texel_rgba),
		.coord_u     (coord_u),
		.coord_v     (coord_v),
		.push        (push),
		.push_entry  (push_entry)
	);

	tsb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	tsb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.done   (done),
		.status (status),
		.chan   (chan)
	);

	assign chan_red   = chan[0];
	assign chan_green = chan[1];
	assign chan_blue  = chan[2];
	assign chan_alpha = chan[3];

`ifndef NO_ASSERTIONS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(credits_q <= QCNT_W'(QUEUE_DEPTH)) && !(pop && credits_q == '0))
		else $error("credit count out of range");
`endif

endmodule
